@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/irpwc_pkg.sv @@
`timescale 1ns / 1ps
package irpwc_pkg;

  localparam int MAX_DURATIONS_DEF = 64;
  localparam int COUNT_WIDTH_DEF   = 16;

  localparam int DUR_W   = 16;
  localparam int POS_W   = 6;
  localparam int TOTAL_W = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MARK_LEVEL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP_LIMIT  = 1'd1;

  localparam logic [DUR_W-1:0] GAP_LIMIT_RST = 16'd200;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_MARK,
    PH_SPACE,
    PH_END,
    PH_SHOW
  } phase_t;

  typedef struct packed {
    logic clear;
    logic count;
    logic store;
    logic rd_start;
    logic rd_next;
  } cmd_t;

  typedef struct packed {
    logic is_mark;
    logic gap_hit;
    logic last;
  } sts_t;

endpackage

@@ rtl/irpwc_if.sv @@
`timescale 1ns / 1ps
interface irpwc_in_if;
  logic valid;
  logic ready;
  logic level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

interface irpwc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] duration;
  logic [5:0]  position;
  logic        is_mark;
  logic        last;
  logic        overflowed;
  logic [6:0]  total;

  modport source (output valid, output duration, output position, output is_mark,
                  output last, output overflowed, output total, input ready);
  modport sink   (input valid, input duration, input position, input is_mark,
                  input last, input overflowed, input total, output ready);
endinterface

@@ rtl/irpwc_ram.sv @@
`timescale 1ns / 1ps
module irpwc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/irpwc_dp.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module irpwc_dp
  import irpwc_pkg::*;
#(
  parameter int MAX_DURATIONS = MAX_DURATIONS_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_level,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [DUR_W-1:0]      out_duration,
  output logic [POS_W-1:0]      out_position,
  output logic                  out_is_mark,
  output logic                  out_overflowed,
  output logic [TOTAL_W-1:0]    out_total
);

  localparam int AW = $clog2(MAX_DURATIONS);
  localparam int SW = $clog2(MAX_DURATIONS + 1);

  logic                   mark_level_r;
  logic [DUR_W-1:0]       gap_limit_r;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt, tick_inc;
  logic [SW-1:0]          stored_r, stored_nxt;
  logic                   dropped_r, dropped_nxt;
  logic [AW-1:0]          rd_idx_r, rd_idx_nxt;
  logic                   room;
  logic [DUR_W-1:0]       dur_sat;
  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_raddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_level_r <= 1'b0;
      gap_limit_r  <= GAP_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MARK_LEVEL: mark_level_r <= cfg_wdata[0];
        CFG_GAP_LIMIT:  gap_limit_r  <= cfg_wdata[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  assign tick_inc = (tick_r == '1) ? tick_r : tick_r + 1'b1;
  assign dur_sat  = (32'(tick_inc) > 32'h0000_FFFF) ? '1 : DUR_W'(tick_inc);
  assign room     = stored_r < SW'(MAX_DURATIONS);

  assign sts.is_mark = (in_level == mark_level_r);
  assign sts.gap_hit = 32'(tick_inc) > 32'(gap_limit_r);
  assign sts.last    = (SW'(rd_idx_r) + 1'b1) == stored_r;

  always_comb begin
    tick_nxt    = tick_r;
    stored_nxt  = stored_r;
    dropped_nxt = dropped_r;
    if (cmd.clear) begin
      tick_nxt    = '0;
      stored_nxt  = '0;
      dropped_nxt = 1'b0;
    end else if (cmd.store) begin
      tick_nxt = '0;
      if (room) begin
        stored_nxt = stored_r + 1'b1;
      end else begin
        dropped_nxt = 1'b1;
      end
    end else if (cmd.count) begin
      tick_nxt = tick_inc;
    end
  end

  always_comb begin
    rd_idx_nxt = rd_idx_r;
    if (cmd.rd_start) begin
      rd_idx_nxt = '0;
    end else if (cmd.rd_next) begin
      rd_idx_nxt = rd_idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      stored_r  <= '0;
      dropped_r <= 1'b0;
    end else begin
      tick_r    <= tick_nxt;
      stored_r  <= stored_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx_r <= rd_idx_nxt;
  end

  assign ram_we    = cmd.store && room;
  assign ram_re    = cmd.rd_start || cmd.rd_next;
  assign ram_raddr = rd_idx_nxt;

  irpwc_ram #(
    .WIDTH (DUR_W),
    .DEPTH (MAX_DURATIONS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (stored_r[AW-1:0]),
    .wdata (dur_sat),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (out_duration)
  );

  assign out_position   = POS_W'(rd_idx_r);
  assign out_is_mark    = ~rd_idx_r[0];
  assign out_overflowed = dropped_r;
  assign out_total      = TOTAL_W'(stored_r);

  `ASSERT_IMPL(a_stored_bound, clk, rst_n, 1'b1, stored_r <= SW'(MAX_DURATIONS), "stored count beyond buffer depth")
  `ASSERT_NEXT(a_drop_flag, clk, rst_n, cmd.store && !room && !cmd.clear, dropped_r, "full buffer store did not set dropped")

endmodule

@@ rtl/irpwc_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module irpwc_ctrl
  import irpwc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  phase_t state_r, state_nxt;
  logic   in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      PH_IDLE: begin
        if (in_acc && sts.is_mark) state_nxt = PH_MARK;
      end
      PH_MARK: begin
        if (in_acc && !sts.is_mark) state_nxt = PH_SPACE;
      end
      PH_SPACE: begin
        if (in_acc) begin
          if (sts.gap_hit) begin
            state_nxt = PH_END;
          end else if (sts.is_mark) begin
            state_nxt = PH_MARK;
          end
        end
      end
      PH_END: begin
        if (in_acc) state_nxt = PH_SHOW;
      end
      PH_SHOW: begin
        if (out_acc && sts.last) state_nxt = PH_IDLE;
      end
      default: state_nxt = PH_IDLE;
    endcase
  end

  // in_ready is high in every capture state and out_valid high in PH_SHOW
  always_comb begin
    in_ready  = 1'b1;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      PH_IDLE: begin
        cmd.clear = in_valid && sts.is_mark;
      end
      PH_MARK: begin
        cmd.count = in_valid;
        cmd.store = in_valid && !sts.is_mark;
      end
      PH_SPACE: begin
        cmd.count = in_valid;
        cmd.store = in_valid && !sts.gap_hit && sts.is_mark;
      end
      PH_END: begin
        cmd.rd_start = in_valid;
      end
      PH_SHOW: begin
        in_ready    = 1'b0;
        out_valid   = 1'b1;
        cmd.rd_next = out_ready && !sts.last;
      end
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `ASSERT_IMPL(a_no_overlap, clk, rst_n, out_valid, !in_ready, "request taken during readout")
  `ASSERT_NEXT(a_end_to_show, clk, rst_n, state_r == PH_END && in_valid, state_r == PH_SHOW, "command end did not start readout")
  `ASSERT_NEXT(a_show_done, clk, rst_n, state_r == PH_SHOW && out_acc && sts.last, state_r == PH_IDLE, "readout did not finish on last")

endmodule

@@ rtl/ir_pulse_width_capture.sv @@
// Infrared remote pulse-width capture.
// in_ch: one request per timer tick carrying the sampled receiver level.
// out_ch: one request per stored mark or space duration of a command.
// cfg_we/cfg_idx/cfg_wdata: index 0 mark_level, index 1 gap_limit.
// Ticks are taken one per cycle while a command is captured: a stored
// duration costs a single buffer write. A space longer than gap_limit ends
// the command; the tick after that starts the readout from the duration
// buffer, whose registered read port sets the timing: the first duration
// appears in the cycle after that tick, then one per cycle while out_ch.ready
// stays high, in_ch.ready low throughout. A stalled receiver holds the
// current duration on out_ch until taken. After the last one the block
// returns to idle and waits for the next mark.
// Reset (rst_n low at a clock edge) returns to idle, clears counters and
// restores mark_level 0 and gap_limit 200. The buffer is not cleared.
`timescale 1ns / 1ps
module ir_pulse_width_capture
  import irpwc_pkg::*;
#(
  parameter int MAX_DURATIONS = MAX_DURATIONS_DEF,
  parameter int COUNT_WIDTH   = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  irpwc_in_if.sink              in_ch,
  irpwc_out_if.source           out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  irpwc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  irpwc_dp #(
    .MAX_DURATIONS (MAX_DURATIONS),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .in_level       (in_ch.level),
    .cmd            (cmd),
    .sts            (sts),
    .out_duration   (out_ch.duration),
    .out_position   (out_ch.position),
    .out_is_mark    (out_ch.is_mark),
    .out_overflowed (out_ch.overflowed),
    .out_total      (out_ch.total)
  );

  assign out_ch.last = sts.last;

endmodule
